// File: sv/pqe_pkg.sv
// Shared widths, register indexes and limits of the product-quantization encoder.
// Used by the top level and by its port checker; depends on nothing else.
package pqe_pkg;

	// Fixed field widths of the stream beats
	localparam int CI_W   = 8;   // centroid index of a load beat
	localparam int EI_W   = 7;   // element index of a load beat
	localparam int CODE_W = 8;   // nearest-centroid code
	localparam int SUB_W  = 7;   // subspace index of a result
	localparam int OUT_DATA_W = ((CODE_W + SUB_W + 7) / 8) * 8;

	// Configuration port
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SUBSPACES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CENTROIDS = 2'd2;

	// Register widths and reset values
	localparam int LEN_W  = 8;
	localparam int SUBS_W = 8;
	localparam int CENT_W = 9;
	localparam logic [LEN_W-1:0]  VECTOR_LENGTH_RST = 8'd128;
	localparam logic [SUBS_W-1:0] NUM_SUBSPACES_RST = 8'd8;
	localparam logic [CENT_W-1:0] NUM_CENTROIDS_RST = 9'd256;

	// Distance arithmetic: unsigned sums that saturate at the top
	localparam int DIST_W = 40;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	// Magnitudes at or above 2^SQ_LIM_BITS square past the distance range
	localparam int SQ_LIM_BITS = 20;
	localparam int ABS_EXT_W   = 33;

	// Operation codes carried in tuser
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ELEMENT = 1'b1;

endpackage

// File: sv/pq_nearest_centroid_encoder.sv
// Product-quantization encoder: codebook store, one shared distance unit and its sequencer.
// Depends on pqe_pkg for field widths, register indexes and distance limits.
//
// Usage. Input beats arrive on s_axis. tuser selects the kind of beat: a load beat writes one
// codebook word (tdata holds centroid_index, element_index, value) and a element beat feeds the
// next vector element (value only is used). Results leave on m_axis: tdata holds the code and
// the subspace index, tlast marks the final subspace of a vector. Configuration registers
// (vector_length, num_subspaces, num_centroids) are written through cfg_wr_*; a write to any of
// them restarts the vector in progress and keeps the codebook.
// Throughput. A load beat leaves s_axis_tready high. An element beat holds s_axis_tready low
// while a sweep over the K effective centroids runs: the single subtract-square-accumulate unit
// visits one centroid per cycle, with a three-stage pipe (store read, square, accumulate).
// The last element of a subspace also finds the minimum during that same sweep; its code
// moves into the output register from ST_FIN once the output register is free.
// Reset and configuration. After reset and after each register write an 8-step divider
// works out the subspace widths, so tready stays low while it runs. The codebook is not
// cleared and must be loaded before use.
// Stalls. A finished code waits in the output register; load beats are still taken while it
// waits, but the next code is held back until the receiver has taken the previous one.
module pq_nearest_centroid_encoder #(
	parameter int MAX_DIM       = 128,
	parameter int MAX_CENTROIDS = 256,
	parameter int VALUE_BITS    = 16,
	localparam int IN_DATA_W =
		((pqe_pkg::CI_W + pqe_pkg::EI_W + VALUE_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pqe_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
	input  logic [pqe_pkg::CFG_W-1:0]         cfg_wr_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// centroid_index, element_index, value (from bit 0 up), zero padded
	input  logic [IN_DATA_W-1:0]              s_axis_tdata,
	// operation
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// code, subspace_index (from bit 0 up), zero padded
	output logic [pqe_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                              m_axis_tlast
);

	localparam int CW    = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
	localparam int CB_N  = MAX_CENTROIDS * MAX_DIM;
	localparam int CB_AW = (CB_N > 1) ? $clog2(CB_N) : 1;
	localparam int LW    = pqe_pkg::LEN_W;
	localparam int DW    = pqe_pkg::DIST_W;

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIVI  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]                 state_q;
	logic [LW-1:0]              vl_q;
	logic [pqe_pkg::SUBS_W-1:0] ns_q;
	logic [pqe_pkg::CENT_W-1:0] nc_q;

	logic [2:0]    div_cnt_q;
	logic [LW-1:0] div_quo_q;   // subspace base width once the divider is done
	logic [LW-1:0] div_rem_q;   // number of subspaces that are one element wider

	logic [LW-1:0] elem_q;
	logic [LW-1:0] sub_q;
	logic [LW-1:0] pos_q;
	logic          first_q;
	logic          last_elem_q;
	logic          last_vec_q;

	logic          iss_on_q;
	logic [CW-1:0] iss_c_q;
	logic          v_s1;
	logic          v_s2;
	logic [CW-1:0] c_s1;
	logic [CW-1:0] c_s2;

	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] cb_rd_s1;
	logic [DW-1:0]         pd_rd_s1;
	logic [DW-1:0]         sq_s2;
	logic [DW-1:0]         base_s2;
	logic [DW-1:0]         best_q;
	logic [CW-1:0]         best_c_q;

	logic                         m_valid_q;
	logic [pqe_pkg::CODE_W-1:0]   m_code_q;
	logic [pqe_pkg::SUB_W-1:0]    m_sub_q;
	logic                         m_last_q;

	logic [VALUE_BITS-1:0] cb_mem [CB_N];
	logic [DW-1:0]         pd_mem [MAX_CENTROIDS];

	logic [pqe_pkg::CI_W-1:0] in_ci;
	logic [pqe_pkg::EI_W-1:0] in_ei;
	logic [VALUE_BITS-1:0]    in_val;
	logic                     s_acc;
	logic                     load_ok;
	logic [CB_AW-1:0]         cb_waddr;
	logic [CB_AW-1:0]         cb_raddr;

	logic [LW-1:0]              len_eff;
	logic [LW-1:0]              m_eff;
	logic [pqe_pkg::CENT_W-1:0] k_eff;
	logic [CW-1:0]              k_m1;

	logic [LW:0] div_trial;
	logic [LW:0] wdt;
	logic [LW:0] pos_nx;
	logic [LW:0] sub_nx;

	logic [VALUE_BITS:0]          diff_s1;
	logic [VALUE_BITS:0]          abs_s1;
	logic [pqe_pkg::ABS_EXT_W-1:0] abs_w;
	logic [pqe_pkg::SQ_LIM_BITS-1:0] mul_in;
	logic [DW-1:0]                sq_s1;
	logic [DW:0]                  sum_w;
	logic [DW-1:0]                sum_s2;
	logic                         out_free;
	logic                         cfg_hit;

	// Beat unpacking and handshake
	assign in_ci  = s_axis_tdata[pqe_pkg::CI_W-1:0];
	assign in_ei  = s_axis_tdata[pqe_pkg::CI_W +: pqe_pkg::EI_W];
	assign in_val = s_axis_tdata[pqe_pkg::CI_W + pqe_pkg::EI_W +: VALUE_BITS];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign load_ok = (32'(in_ci) < MAX_CENTROIDS) && (32'(in_ei) < MAX_DIM);
	assign cb_waddr = CB_AW'(32'(in_ci) * MAX_DIM + 32'(in_ei));
	assign cb_raddr = CB_AW'(32'(iss_c_q) * MAX_DIM + 32'(elem_q));
	assign out_free = !m_valid_q || m_axis_tready;
	assign cfg_hit  = cfg_wr_en && (cfg_wr_index == pqe_pkg::REG_VECTOR_LENGTH ||
		cfg_wr_index == pqe_pkg::REG_NUM_SUBSPACES ||
		cfg_wr_index == pqe_pkg::REG_NUM_CENTROIDS);

	// Effective register values: zero acts as one, large values clamp
	always_comb begin
		if (vl_q == '0) begin
			len_eff = LW'(1);
		end else if (32'(vl_q) > MAX_DIM) begin
			len_eff = LW'(MAX_DIM);
		end else begin
			len_eff = vl_q;
		end
		if (ns_q == '0) begin
			m_eff = LW'(1);
		end else if (ns_q > len_eff) begin
			m_eff = len_eff;
		end else begin
			m_eff = ns_q;
		end
		if (nc_q == '0) begin
			k_eff = pqe_pkg::CENT_W'(1);
		end else if (32'(nc_q) > MAX_CENTROIDS) begin
			k_eff = pqe_pkg::CENT_W'(MAX_CENTROIDS);
		end else begin
			k_eff = nc_q;
		end
		k_m1 = CW'(k_eff - pqe_pkg::CENT_W'(1));
	end

	// Divider step and subspace bookkeeping
	always_comb begin
		div_trial = {div_rem_q, div_quo_q[LW-1]};
		wdt    = {1'b0, div_quo_q} + ((sub_q < div_rem_q) ? (LW+1)'(1) : '0);
		pos_nx = {1'b0, pos_q} + (LW+1)'(1);
		sub_nx = {1'b0, sub_q} + (LW+1)'(1);
	end

	// Square of the difference, saturating beyond the distance range
	always_comb begin
		diff_s1 = {val_q[VALUE_BITS-1], val_q} - {cb_rd_s1[VALUE_BITS-1], cb_rd_s1};
		abs_s1  = diff_s1[VALUE_BITS] ? (~diff_s1 + 1'b1) : diff_s1;
		abs_w   = pqe_pkg::ABS_EXT_W'(abs_s1);
		mul_in  = abs_w[pqe_pkg::SQ_LIM_BITS-1:0];
		if (|(abs_w >> pqe_pkg::SQ_LIM_BITS)) begin
			sq_s1 = pqe_pkg::DIST_MAX;
		end else begin
			sq_s1 = DW'(mul_in) * DW'(mul_in);
		end
	end

	// Saturating accumulate
	always_comb begin
		sum_w  = {1'b0, base_s2} + {1'b0, sq_s2};
		sum_s2 = sum_w[DW] ? pqe_pkg::DIST_MAX : sum_w[DW-1:0];
	end

	// Codebook and partial-distance memories, with the data path registers
	always_ff @(posedge clk) begin
		if (s_acc && s_axis_tuser == pqe_pkg::OP_LOAD && load_ok) begin
			cb_mem[cb_waddr] <= in_val;
		end
		cb_rd_s1 <= cb_mem[cb_raddr];
		pd_rd_s1 <= pd_mem[iss_c_q];
		if (v_s2) begin
			pd_mem[c_s2] <= sum_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && s_axis_tuser == pqe_pkg::OP_ELEMENT) begin
			val_q <= in_val;
		end
		c_s1    <= iss_c_q;
		c_s2    <= c_s1;
		sq_s2   <= sq_s1;
		base_s2 <= first_q ? '0 : pd_rd_s1;
		// Running minimum over the sweep; strict compare keeps the lowest index on ties
		if (v_s2 && last_elem_q && (c_s2 == '0 || sum_s2 < best_q)) begin
			best_q   <= sum_s2;
			best_c_q <= c_s2;
		end
		if (state_q == ST_FIN && last_elem_q && out_free) begin
			m_code_q <= pqe_pkg::CODE_W'(best_c_q);
			m_sub_q  <= pqe_pkg::SUB_W'(sub_q);
			m_last_q <= last_vec_q;
		end
	end

	// Sequencer, registers, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_DIVI;
			vl_q        <= pqe_pkg::VECTOR_LENGTH_RST;
			ns_q        <= pqe_pkg::NUM_SUBSPACES_RST;
			nc_q        <= pqe_pkg::NUM_CENTROIDS_RST;
			div_cnt_q   <= '0;
			div_quo_q   <= '0;
			div_rem_q   <= '0;
			elem_q      <= '0;
			sub_q       <= '0;
			pos_q       <= '0;
			first_q     <= 1'b0;
			last_elem_q <= 1'b0;
			last_vec_q  <= 1'b0;
			iss_on_q    <= 1'b0;
			iss_c_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			v_s1 <= iss_on_q;
			v_s2 <= v_s1;
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			// Issue one centroid a cycle until the last one is read
			if (iss_on_q) begin
				if (iss_c_q == k_m1) begin
					iss_on_q <= 1'b0;
				end else begin
					iss_c_q <= iss_c_q + 1'b1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (s_acc && s_axis_tuser == pqe_pkg::OP_ELEMENT) begin
						first_q     <= (pos_q == '0);
						last_elem_q <= (pos_nx >= wdt);
						last_vec_q  <= (sub_nx >= {1'b0, m_eff});
						iss_on_q    <= 1'b1;
						iss_c_q     <= '0;
						state_q     <= ST_SWEEP;
					end
				end
				ST_DIVI: begin
					div_quo_q <= len_eff;
					div_rem_q <= '0;
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					// Restoring division, one quotient bit a cycle
					if (div_trial >= {1'b0, m_eff}) begin
						div_rem_q <= LW'(div_trial - {1'b0, m_eff});
						div_quo_q <= {div_quo_q[LW-2:0], 1'b1};
					end else begin
						div_rem_q <= div_trial[LW-1:0];
						div_quo_q <= {div_quo_q[LW-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 3'd7) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (v_s2 && c_s2 == k_m1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_elem_q) begin
						pos_q   <= pos_q + 1'b1;
						elem_q  <= elem_q + 1'b1;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						m_valid_q <= 1'b1;
						pos_q     <= '0;
						if (last_vec_q) begin
							sub_q  <= '0;
							elem_q <= '0;
						end else begin
							sub_q  <= sub_q + 1'b1;
							elem_q <= elem_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Register writes restart the vector and recompute the subspace widths
			if (cfg_wr_en) begin
				case (cfg_wr_index)
					pqe_pkg::REG_VECTOR_LENGTH: vl_q <= cfg_wr_data[LW-1:0];
					pqe_pkg::REG_NUM_SUBSPACES: ns_q <= cfg_wr_data[pqe_pkg::SUBS_W-1:0];
					pqe_pkg::REG_NUM_CENTROIDS: nc_q <= cfg_wr_data;
					default: begin
					end
				endcase
			end
			if (cfg_hit) begin
				elem_q  <= '0;
				sub_q   <= '0;
				pos_q   <= '0;
				state_q <= ST_DIVI;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = pqe_pkg::OUT_DATA_W'({m_sub_q, m_code_q});
	assign m_axis_tlast  = m_last_q;

endmodule

// File: sv/pqe_chk.sv
// Port-level checker for the product-quantization encoder, bound to the top level.
// Depends on pqe_pkg for register indexes and operation codes.
module pqe_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_wr_en,
	input logic [pqe_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	// operation
	input logic                           s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	// code, subspace_index (from bit 0 up)
	input logic [pqe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tlast
);

	logic s_acc;
	logic cfg_hit;

	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign cfg_hit = cfg_wr_en && (cfg_wr_index == pqe_pkg::REG_VECTOR_LENGTH ||
		cfg_wr_index == pqe_pkg::REG_NUM_SUBSPACES ||
		cfg_wr_index == pqe_pkg::REG_NUM_CENTROIDS);

	// An element beat starts a sweep, so the input side closes at once
	a_elem_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_axis_tuser == pqe_pkg::OP_ELEMENT |=> !s_axis_tready)
		else $error("input still ready after an element beat");

	// A load beat only writes the codebook and leaves the input open, unless a register write comes too
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_axis_tuser == pqe_pkg::OP_LOAD && !cfg_wr_en |=> s_axis_tready)
		else $error("input closed after a load beat");

	// A register write restarts the width divider
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> !s_axis_tready)
		else $error("input ready straight after a register write");

	// A new code only appears at the end of a sweep
	a_code_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("code produced while the input side was open");

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

endmodule

bind pq_nearest_centroid_encoder pqe_chk u_pqe_chk (.*);
